// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the login frame builder RTL.
// No dependencies; included inside lfb_frame_seq, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with rst_n low masking the check.
`define LFB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("login frame builder: same-cycle check failed");

// Next-cycle implication, checked on clk with rst_n low masking the check.
`define LFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("login frame builder: next-cycle check failed");

`endif

// ----- rtl/core/lfb_pkg.sv -----
// Types, frame layout constants and CRC byte-step functions for the login frame builder.
// No dependencies; imported by every lfb module and the top level.
package lfb_pkg;

  localparam int unsigned FRAME_LEN = 27;
  localparam int unsigned POS_W     = 5;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      crc_t;

  // One beat of the result channel
  typedef struct packed {
    byte_t data;
    logic  last;
  } beat_t;

  // Byte positions inside the frame
  localparam pos_t POS_REQ_A      = pos_t'(5);   // request bytes 0..6
  localparam pos_t POS_HB0        = pos_t'(12);
  localparam pos_t POS_REQ_B      = pos_t'(13);  // request bytes 7..13
  localparam pos_t POS_HB1        = pos_t'(20);
  localparam pos_t POS_RCRC_LO    = pos_t'(21);
  localparam pos_t POS_RCRC_HI    = pos_t'(22);
  localparam pos_t POS_HB2        = pos_t'(23);
  localparam pos_t POS_FCRC_LO    = pos_t'(24);
  localparam pos_t POS_FCRC_HI    = pos_t'(25);
  localparam pos_t POS_END        = pos_t'(26);
  localparam pos_t POS_FCRC_FIRST = pos_t'(3);
  localparam pos_t POS_RCRC_FIRST = pos_t'(8);   // request byte 3

  localparam int unsigned HDR_LEN = 5;
  localparam byte_t HDR_BYTES [HDR_LEN] = '{8'h02, 8'hAA, 8'hAA, 8'h86, 8'h81};

  localparam int unsigned REQ_RAW_LEN = 14;
  localparam byte_t REQ_TPL [REQ_RAW_LEN] = '{
    8'h0F, 8'h00, 8'h00, 8'hFD, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h25, 8'h12, 8'h10, 8'h00, 8'h00, 8'h04
  };

  localparam byte_t BIT7_MASK  = 8'h80;
  localparam byte_t END_BYTE   = 8'h03;
  localparam crc_t  RCRC_INIT  = 16'hFFFF;
  localparam crc_t  RCRC_POLY  = 16'hA001;
  localparam crc_t  FCRC_INIT  = 16'h0000;
  localparam crc_t  FCRC_POLY  = 16'h1021;
  localparam crc_t  FCRC_OR    = 16'h8080;

  // Raw request byte (before bit 7 is forced) for request index 0..13
  function automatic byte_t req_byte(input logic [3:0] idx, input logic [31:0] id);
    byte_t b;
    b = 8'h00;
    if (idx < 4'(REQ_RAW_LEN)) begin
      b = REQ_TPL[idx];
    end
    unique case (idx)
      4'd4:    b = id[31:24];
      4'd5:    b = id[23:16];
      4'd6:    b = id[15:8];
      4'd7:    b = id[7:0];
      default: b = b;
    endcase
    return b;
  endfunction

  // Reflected CRC-16, one byte, LSB first
  function automatic crc_t crc_refl_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ RCRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // MSB-first CRC-16, one byte
  function automatic crc_t crc_msb_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = (c << 1) ^ FCRC_POLY;
      else       c = c << 1;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/lfb_in_reg.sv -----
// Input holding register: parks one device id until the frame sequencer takes it.
// Depends on lfb_pkg.
module lfb_in_reg
  import lfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_device_id,
  input  logic        take,
  output logic        id_vld,
  output logic [31:0] id
);

  logic        vld_r, vld_nxt;
  logic [31:0] id_r;
  logic        accept;

  // Stall while the held id has not been taken
  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;
  assign vld_nxt  = accept || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the id on an accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r <= in_device_id;
    end
  end

  assign id_vld = vld_r;
  assign id     = id_r;

endmodule

// ----- rtl/core/lfb_frame_seq.sv -----
// Frame sequencer: walks the 27 frame positions, packs request bytes and runs both CRCs.
// Depends on lfb_pkg and assert_macros.svh.
module lfb_frame_seq
  import lfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        id_vld,
  input  logic [31:0] id,
  output logic        take,
  input  logic        ready,
  output logic        beat_vld,
  output beat_t       beat
);

  logic        busy_r;
  pos_t        cnt_r;
  logic [31:0] id_r;
  crc_t        rcrc_r, rcrc_nxt;
  crc_t        fcrc_r, fcrc_nxt;
  logic [6:0]  hb_r, hb_nxt;
  logic        adv;
  logic        load;
  byte_t       raw;
  byte_t       obyte;
  logic        is_req;
  logic        is_hb;
  logic        upd_r;
  logic        upd_f;
  logic        is_last;

  assign adv  = busy_r && ready;
  assign load = id_vld && (!busy_r || (adv && is_last));
  assign take = load;

  // Select the byte for the current position
  always_comb begin
    raw     = 8'h00;
    obyte   = 8'h00;
    is_req  = 1'b0;
    is_hb   = 1'b0;
    upd_r   = 1'b0;
    is_last = 1'b0;
    priority if (cnt_r < POS_REQ_A) begin
      obyte = HDR_BYTES[cnt_r[2:0]];
    end else if (cnt_r < POS_HB0) begin
      raw    = req_byte(4'(cnt_r - POS_REQ_A), id_r);
      is_req = 1'b1;
      upd_r  = (cnt_r >= POS_RCRC_FIRST);
    end else if (cnt_r == POS_HB0 || cnt_r == POS_HB1) begin
      obyte = BIT7_MASK | {1'b0, hb_r};
      is_hb = 1'b1;
    end else if (cnt_r < POS_HB1) begin
      raw    = req_byte(4'(cnt_r - POS_REQ_B + pos_t'(7)), id_r);
      is_req = 1'b1;
      upd_r  = 1'b1;
    end else if (cnt_r == POS_RCRC_LO) begin
      raw    = rcrc_r[7:0];
      is_req = 1'b1;
    end else if (cnt_r == POS_RCRC_HI) begin
      raw    = rcrc_r[15:8];
      is_req = 1'b1;
    end else if (cnt_r == POS_HB2) begin
      // two leftover bits, left-aligned to bit 6
      obyte = {1'b1, hb_r[1:0], 5'b0};
      is_hb = 1'b1;
    end else if (cnt_r == POS_FCRC_LO) begin
      obyte = fcrc_r[7:0] | FCRC_OR[7:0];
    end else if (cnt_r == POS_FCRC_HI) begin
      obyte = fcrc_r[15:8] | FCRC_OR[15:8];
    end else begin
      obyte   = END_BYTE;
      is_last = 1'b1;
    end
    if (is_req) begin
      obyte = raw | BIT7_MASK;
    end
  end

  assign upd_f = (cnt_r >= POS_FCRC_FIRST) && (cnt_r <= POS_HB2);

  // Next values of the CRCs and the collected high bits
  always_comb begin
    rcrc_nxt = upd_r ? crc_refl_byte(rcrc_r, raw) : rcrc_r;
    fcrc_nxt = upd_f ? crc_msb_byte(fcrc_r, obyte) : fcrc_r;
    hb_nxt   = hb_r;
    if (is_req) begin
      hb_nxt = {hb_r[5:0], raw[7]};
    end else if (is_hb) begin
      hb_nxt = '0;
    end
  end

  // Control: busy flag and position counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (adv) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + pos_t'(1);
      end
    end
  end

  // Working registers: restart on load, advance with each beat
  always_ff @(posedge clk) begin
    if (load) begin
      id_r   <= id;
      rcrc_r <= RCRC_INIT;
      fcrc_r <= FCRC_INIT;
      hb_r   <= '0;
    end else if (adv) begin
      rcrc_r <= rcrc_nxt;
      fcrc_r <= fcrc_nxt;
      hb_r   <= hb_nxt;
    end
  end

  assign beat_vld  = busy_r;
  assign beat.data = obyte;
  assign beat.last = is_last;

`include "assert_macros.svh"

  `LFB_ASSERT_IMPL(a_cnt_range, busy_r, cnt_r <= POS_END)
  `LFB_ASSERT_NEXT(a_cnt_hold, busy_r && !ready && !load, $stable(cnt_r) && busy_r)
  `LFB_ASSERT_NEXT(a_frame_done, adv && is_last && !load, !busy_r)

endmodule

// ----- rtl/core/lfb_out_reg.sv -----
// Result register: holds one frame beat for the output channel.
// Depends on lfb_pkg.
module lfb_out_reg
  import lfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_vld,
  input  beat_t      beat,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic  vld_r;
  beat_t beat_r;

  // Load when empty or when the held beat leaves
  assign ready = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= beat_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && beat_vld) begin
      beat_r <= beat;
    end
  end

  assign out_valid      = vld_r;
  assign out_frame_byte = beat_r.data;
  assign out_last_byte  = beat_r.last;

endmodule

// ----- rtl/core/login_frame_builder_unit.sv -----
// Login frame builder: one 32-bit device id in, 27 frame bytes out, one beat per cycle
// while out_stall is low. While a frame is being built, the next id waits in the input
// register and its frame follows the end byte with no gap.
// Reset (rst_n low, synchronous) empties the input, sequencer and output registers.
module login_frame_builder_unit
  import lfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_device_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);

  logic        id_vld;
  logic [31:0] id;
  logic        take;
  logic        ready;
  logic        beat_vld;
  beat_t       beat;

  lfb_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_device_id (in_device_id),
    .take         (take),
    .id_vld       (id_vld),
    .id           (id)
  );

  lfb_frame_seq u_frame_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .id_vld   (id_vld),
    .id       (id),
    .take     (take),
    .ready    (ready),
    .beat_vld (beat_vld),
    .beat     (beat)
  );

  lfb_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .beat_vld       (beat_vld),
    .beat           (beat),
    .ready          (ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ----- sim/login_frame_builder_unit_tb.sv -----
// Self-checking testbench for login_frame_builder_unit: device ids in, 27-byte login frames out.
// Depends on lfb_pkg for beat and CRC types, frame template bytes and polynomials.
// A local frame predictor fills a queue of expected beats that the output monitor checks.
module login_frame_builder_unit_tb;
  import lfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_BATCH   = 100;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [31:0] in_device_id   = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  logic [31:0] pending_ids [$];
  beat_t       frame_bytes_due [$];
  bit          id_accepted       = 1'b0;
  int          sender_idle_pct   = 0;
  int          receiver_idle_pct = 0;
  int          mismatches        = 0;
  int          quiet_cycles      = 0;

  login_frame_builder_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_device_id   (in_device_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Build the full login frame for one id and queue its 27 beats
  function automatic void predict_login_frame(input logic [31:0] id);
    byte_t req [16];
    byte_t frame [FRAME_LEN];
    crc_t  crc;
    byte_t hb;
    logic  fb;
    int    n;
    int    cnt;
    beat_t b;
    for (int i = 0; i < REQ_RAW_LEN; i++) req[i] = REQ_TPL[i];
    req[4] = id[31:24];
    req[5] = id[23:16];
    req[6] = id[15:8];
    req[7] = id[7:0];

    // Reflected CRC over request bytes 3..13, one bit at a time, LSB first
    crc = RCRC_INIT;
    for (int i = 3; i < REQ_RAW_LEN; i++) begin
      for (int k = 0; k < 8; k++) begin
        fb  = crc[0] ^ req[i][k];
        crc = crc >> 1;
        if (fb) crc = crc ^ RCRC_POLY;
      end
    end
    req[14] = crc[7:0];
    req[15] = crc[15:8];

    for (int i = 0; i < HDR_LEN; i++) frame[i] = HDR_BYTES[i];
    n = HDR_LEN;

    // Pack seven bits per byte, collecting the stripped top bits after each group
    hb  = '0;
    cnt = 0;
    for (int i = 0; i < 16; i++) begin
      hb = {hb[6:0], req[i][7]};
      frame[n] = req[i] | BIT7_MASK;
      n++;
      cnt++;
      if (cnt == 7) begin
        frame[n] = hb | BIT7_MASK;
        n++;
        hb  = '0;
        cnt = 0;
      end
    end
    if (cnt != 0) begin
      hb = hb << (7 - cnt);
      frame[n] = hb | BIT7_MASK;
      n++;
    end

    // MSB-first CRC over the frame from the first protocol byte onward
    crc = FCRC_INIT;
    for (int i = 3; i < n; i++) begin
      for (int k = 7; k >= 0; k--) begin
        fb  = crc[15] ^ frame[i][k];
        crc = crc << 1;
        if (fb) crc = crc ^ FCRC_POLY;
      end
    end
    crc = crc | FCRC_OR;
    frame[n]     = crc[7:0];
    frame[n + 1] = crc[15:8];
    frame[n + 2] = END_BYTE;

    for (int i = 0; i < FRAME_LEN; i++) begin
      b.data = frame[i];
      b.last = (i == FRAME_LEN - 1);
      frame_bytes_due.push_back(b);
    end
  endfunction

  // Mix uniform ids, ids built from byte values around the bit-7 boundary, and one-hot or one-cold ids
  function automatic logic [31:0] random_device_id();
    logic [31:0] id;
    id = $urandom;
    case ($urandom_range(3))
      2: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(3))
            0:       id[k*8 +: 8] = 8'h00;
            1:       id[k*8 +: 8] = 8'hFF;
            2:       id[k*8 +: 8] = 8'h80;
            default: id[k*8 +: 8] = 8'h7F;
          endcase
        end
      end
      3: begin
        id = 32'h1 << $urandom_range(31);
        if ($urandom_range(1)) id = ~id;
      end
      default: id = id;
    endcase
    return id;
  endfunction

  // Hold until every queued id is taken and every expected beat has arrived
  task automatic wait_frames_drained();
    while (pending_ids.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(posedge clk);
  endtask

  // Drive the id channel and the result stall on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || id_accepted) begin
        if (pending_ids.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid     <= 1'b1;
          in_device_id <= pending_ids.pop_front();
        end else begin
          in_valid     <= 1'b0;
          in_device_id <= $urandom;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Sample both channels on the rising edge: predict on id beats, check frame beats
  always @(posedge clk) begin
    beat_t want;
    id_accepted = rst_n && in_valid && !in_stall;
    if (id_accepted) predict_login_frame(in_device_id);

    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected frame beat: frame_byte %02h last_byte %0b",
               out_frame_byte, out_last_byte);
        mismatches++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_frame_byte !== want.data) begin
          $error("frame_byte: expected %02h, got %02h", want.data, out_frame_byte);
          mismatches++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, out_last_byte);
          mismatches++;
        end
      end
    end

    // Count cycles with no beat on either channel
    if (id_accepted || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed ids: field extremes and bit-7 patterns in every byte
    sender_idle_pct   = 11;
    receiver_idle_pct = 69;
    pending_ids.push_back(32'h0000_0000);
    pending_ids.push_back(32'hFFFF_FFFF);
    pending_ids.push_back(32'h8000_0000);
    pending_ids.push_back(32'h7FFF_FFFF);
    pending_ids.push_back(32'h0000_0001);
    pending_ids.push_back(32'hFFFF_FFFE);
    pending_ids.push_back(32'h8080_8080);
    pending_ids.push_back(32'h7F7F_7F7F);
    pending_ids.push_back(32'hFF00_0000);
    pending_ids.push_back(32'h0000_00FF);
    pending_ids.push_back(32'h5555_5555);
    pending_ids.push_back(32'hAAAA_AAAA);
    pending_ids.push_back(32'h0123_4567);
    pending_ids.push_back(32'h89AB_CDEF);
    pending_ids.push_back(32'h00FF_00FF);
    pending_ids.push_back(32'hFF00_FF00);
    wait_frames_drained();

    // Random ids, slow receiver
    for (int i = 0; i < RANDOM_BATCH; i++) pending_ids.push_back(random_device_id());
    wait_frames_drained();

    // Random ids, slow sender
    sender_idle_pct   = 69;
    receiver_idle_pct = 11;
    for (int i = 0; i < RANDOM_BATCH; i++) pending_ids.push_back(random_device_id());
    wait_frames_drained();

    // Random ids, back to back in both directions
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (int i = 0; i < RANDOM_BATCH; i++) pending_ids.push_back(random_device_id());
    wait_frames_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- login_frame_builder_unit.f -----
+incdir+rtl/core
rtl/core/lfb_pkg.sv
rtl/core/lfb_in_reg.sv
rtl/core/lfb_frame_seq.sv
rtl/core/lfb_out_reg.sv
rtl/core/login_frame_builder_unit.sv
sim/login_frame_builder_unit_tb.sv
